>>> hdl/iis_pkg.sv
// Shared types and constants for the integral image (summed-area table) unit.
// Used by the row accumulator and the top level.
package iis_pkg;

  // Configuration register index width; leaves room for indexes past the list.
  localparam int unsigned CFG_IDX_W = 2;

  // Reset value of both frame size registers, before clamping to the maximum.
  localparam int unsigned SIZE_RESET = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // Control bits that travel with one pixel through the pipeline.
  typedef struct packed {
    logic has_above;     // row above exists, so the line store value counts
    logic last_of_row;
    logic last_of_frame;
  } item_ctrl_t;

endpackage

>>> hdl/integral_image_with_squares_unit.sv
// Top level of the integral image unit: summed-area table of pixels and of
// squared pixels. Depends on iis_pkg, iis_row_acc and iis_ram.
//
// Usage:
// Pixels enter in raster order on the pixel channel (pixel_i with
// pixel_valid_i / pixel_ready_o). Each accepted word yields exactly one result
// word on the result channel (area_sum_o, squared_area_sum_o, last_of_row_o,
// last_of_frame_o with result_valid_o / result_ready_i). The area sum is the
// sum of all pixels from the frame origin to this position inclusive; the
// squared sum is the same over squared pixels.
// Each result passes the middle stage and the output register. Throughput is
// one pixel per clock while result_ready_i is high: the line stores are
// dual-port RAMs, read when a pixel enters and written when its result leaves
// the middle stage, with a bypass register for a one-pixel-wide frame.
// The frame size is set through the write port (index 0: width, index 1:
// height); a write to either index restarts the frame at row 0, column 0.
// Write only while the unit is idle.
// Reset clears the counters, running sums and the pipeline valid flags; the
// frame size returns to 1024 by 1024 (clamped to the maximum). The line stores
// are not cleared; the first row does not use their values.
// When the receiver stalls, the output register holds its word and the middle
// stage can still take one more, so up to two words are buffered before
// pixel_ready_o drops.
module integral_image_with_squares_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned CFG_W  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                   $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1),
  localparam int unsigned AREA_W = PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT),
  localparam int unsigned ASQ_W  = 2 * PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic [PIXEL_BITS-1:0]         pixel_i,
  input  logic                          pixel_valid_i,
  output logic                          pixel_ready_o,
  output logic [AREA_W-1:0]             area_sum_o,
  output logic [ASQ_W-1:0]              squared_area_sum_o,
  output logic                          last_of_row_o,
  output logic                          last_of_frame_o,
  output logic                          result_valid_o,
  input  logic                          result_ready_i
);
  import iis_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned RS_W  = PIXEL_BITS + $clog2(MAX_WIDTH);
  localparam int unsigned RSQ_W = 2 * PIXEL_BITS + $clog2(MAX_WIDTH);

  // Accept stage outputs (combinational from the running sums).
  logic             accept;
  logic [COL_W-1:0] in_col;
  logic [RS_W-1:0]  in_rs;
  logic [RSQ_W-1:0] in_rsq;
  item_ctrl_t       in_ctrl;

  // Middle stage: row sums of the pixel plus the line store read data.
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [RS_W-1:0]  s1_rs_q;
  logic [RSQ_W-1:0] s1_rsq_q;
  item_ctrl_t       s1_ctrl_q;
  logic             s1_go;

  // Bypass for a read of the column that the middle stage writes that cycle.
  logic              fwd_sel_q;
  logic [AREA_W-1:0] fwd_area_q;
  logic [ASQ_W-1:0]  fwd_asq_q;

  logic [AREA_W-1:0] ram_area, above_area, s1_area;
  logic [ASQ_W-1:0]  ram_asq, above_asq, s1_asq;

  // Output register.
  logic              out_valid_q;
  logic [AREA_W-1:0] out_area_q;
  logic [ASQ_W-1:0]  out_asq_q;
  item_ctrl_t        out_ctrl_q;

  assign s1_go         = s1_valid_q && (!out_valid_q || result_ready_i);
  assign pixel_ready_o = !s1_valid_q || s1_go;
  assign accept        = pixel_valid_i && pixel_ready_o;

  iis_row_acc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .CFG_W      (CFG_W),
    .COL_W      (COL_W),
    .RS_W       (RS_W),
    .RSQ_W      (RSQ_W)
  ) u_row_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .col_o       (in_col),
    .row_sum_o   (in_rs),
    .row_sq_o    (in_rsq),
    .ctrl_o      (in_ctrl)
  );

  // Line stores of the previous row's table values, one entry per column.
  iis_ram #(
    .WIDTH (AREA_W),
    .DEPTH (MAX_WIDTH)
  ) u_area_store (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (s1_area),
    .re_i    (accept),
    .raddr_i (in_col),
    .rdata_o (ram_area)
  );

  iis_ram #(
    .WIDTH (ASQ_W),
    .DEPTH (MAX_WIDTH)
  ) u_sq_store (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (s1_asq),
    .re_i    (accept),
    .raddr_i (in_col),
    .rdata_o (ram_asq)
  );

  // The row above only counts past the first row; the bypass covers a write
  // and a read of the same column in one cycle.
  always_comb begin
    above_area = '0;
    above_asq  = '0;
    if (s1_ctrl_q.has_above) begin
      above_area = fwd_sel_q ? fwd_area_q : ram_area;
      above_asq  = fwd_sel_q ? fwd_asq_q  : ram_asq;
    end
    s1_area = AREA_W'(s1_rs_q) + above_area;
    s1_asq  = ASQ_W'(s1_rsq_q) + above_asq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_sel_q   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_sel_q  <= s1_go && (s1_col_q == in_col);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= in_col;
      s1_rs_q    <= in_rs;
      s1_rsq_q   <= in_rsq;
      s1_ctrl_q  <= in_ctrl;
      fwd_area_q <= s1_area;
      fwd_asq_q  <= s1_asq;
    end
    if (s1_go) begin
      out_area_q <= s1_area;
      out_asq_q  <= s1_asq;
      out_ctrl_q <= s1_ctrl_q;
    end
  end

  assign result_valid_o     = out_valid_q;
  assign area_sum_o         = out_area_q;
  assign squared_area_sum_o = out_asq_q;
  assign last_of_row_o      = out_ctrl_q.last_of_row;
  assign last_of_frame_o    = out_ctrl_q.last_of_frame;

endmodule

>>> hdl/iis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module iis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/iis_row_acc.sv
// Frame size registers, column and row counters and the running row sums.
// Depends on iis_pkg.
module iis_row_acc #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned CFG_W = 11,
  parameter int unsigned COL_W = 10,
  parameter int unsigned RS_W  = 18,
  parameter int unsigned RSQ_W = 26
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iis_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]                cfg_data_i,
  input  logic                            accept_i,
  input  logic [PIXEL_BITS-1:0]           pixel_i,
  output logic [COL_W-1:0]                col_o,
  output logic [RS_W-1:0]                 row_sum_o,
  output logic [RSQ_W-1:0]                row_sq_o,
  output iis_pkg::item_ctrl_t             ctrl_o
);
  import iis_pkg::*;

  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SQ_W  = 2 * PIXEL_BITS;
  localparam int unsigned WID_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
  localparam int unsigned HGT_RESET = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

  logic [WID_W-1:0] width_q, width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [RS_W-1:0]  rs_q, rs_d;
  logic [RSQ_W-1:0] rsq_q, rsq_d;
  logic [SQ_W-1:0]  pix_sq;
  logic [CFG_W-1:0] clamp_w, clamp_h;
  logic             restart;
  logic             end_row, end_frame;

  // A value of zero acts as one and a value above the maximum acts as the maximum.
  always_comb begin
    if (cfg_data_i == '0) begin
      clamp_w = CFG_W'(1);
    end else if (cfg_data_i > CFG_W'(MAX_WIDTH)) begin
      clamp_w = CFG_W'(MAX_WIDTH);
    end else begin
      clamp_w = cfg_data_i;
    end
    if (cfg_data_i == '0) begin
      clamp_h = CFG_W'(1);
    end else if (cfg_data_i > CFG_W'(MAX_HEIGHT)) begin
      clamp_h = CFG_W'(MAX_HEIGHT);
    end else begin
      clamp_h = cfg_data_i;
    end
  end

  always_comb begin
    pix_sq    = SQ_W'(pixel_i) * SQ_W'(pixel_i);
    row_sum_o = rs_q + RS_W'(pixel_i);
    row_sq_o  = rsq_q + RSQ_W'(pix_sq);
    end_row   = ({1'b0, col_q} + (COL_W + 1)'(1)) >= (COL_W + 1)'(width_q);
    end_frame = end_row && ((HGT_W'(row_q) + HGT_W'(1)) >= height_q);
    col_o     = col_q;
    ctrl_o.has_above     = (row_q != '0);
    ctrl_o.last_of_row   = end_row;
    ctrl_o.last_of_frame = end_frame;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          width_d = WID_W'(clamp_w);
          restart = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_d = HGT_W'(clamp_h);
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    col_d = col_q;
    row_d = row_q;
    rs_d  = rs_q;
    rsq_d = rsq_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
      rs_d  = '0;
      rsq_d = '0;
    end else if (accept_i) begin
      if (end_row) begin
        col_d = '0;
        rs_d  = '0;
        rsq_d = '0;
        row_d = end_frame ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
        rs_d  = row_sum_o;
        rsq_d = row_sq_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(WID_RESET);
      height_q <= HGT_W'(HGT_RESET);
      col_q    <= '0;
      row_q    <= '0;
      rs_q     <= '0;
      rsq_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rs_q     <= rs_d;
      rsq_q    <= rsq_d;
    end
  end

endmodule

>>> hdl/iis_checker.sv
// Port-level checker for the integral image unit, bound to the top level.
// Depends on integral_image_with_squares_unit.
module iis_checker #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned AREA_W = PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT),
  localparam int unsigned ASQ_W  = 2 * PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pixel_ready_o,
  input logic [AREA_W-1:0] area_sum_o,
  input logic [ASQ_W-1:0]  squared_area_sum_o,
  input logic              last_of_row_o,
  input logic              last_of_frame_o,
  input logic              result_valid_o,
  input logic              result_ready_i
);

  // Once reset has been seen low, no result word shows in the next cycle.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !result_valid_o)
    else $error("result valid during reset");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(area_sum_o) && $stable(squared_area_sum_o) &&
      $stable(last_of_row_o) && $stable(last_of_frame_o))
    else $error("stalled result word changed");

  // The last pixel of a frame is always the last pixel of a row.
  a_frame_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_frame_o |-> last_of_row_o)
    else $error("frame end without row end");

  // Every integer is at most its square, so the squared table never falls below the plain one.
  a_sq_ge_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> squared_area_sum_o >= ASQ_W'(area_sum_o))
    else $error("squared sum below plain sum");

  // With the output register empty the pipeline always has room for a pixel.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> pixel_ready_o)
    else $error("input blocked with empty output");

endmodule

bind integral_image_with_squares_unit iis_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT),
  .PIXEL_BITS (PIXEL_BITS)
) u_iis_checker (.*);
